@@ src/scc_pkg.sv @@
// scc_pkg: shared constants, register indexes and store port types
// for the surface cube classifier
// no dependencies
package scc_pkg;

    // grid limits and coordinate widths
    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 1024;
    localparam int X_W   = $clog2(MAX_X);
    localparam int Y_W   = $clog2(MAX_Y);
    localparam int Z_W   = $clog2(MAX_Z);
    localparam int CELL_W = X_W + Y_W;
    localparam int SX_W  = 9;
    localparam int SY_W  = 9;
    localparam int SZ_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SZ_W-1:0] SIZE_MIN = 11'd2;
    localparam logic [SZ_W-1:0] SIZE_RST = 11'd256;
    localparam logic [SZ_W-1:0] SIZE_X_MAX = SZ_W'(MAX_X);
    localparam logic [SZ_W-1:0] SIZE_Y_MAX = SZ_W'(MAX_Y);
    localparam logic [SZ_W-1:0] SIZE_Z_MAX = SZ_W'(MAX_Z);

    // store read request: one plane entry and one row entry
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
        logic [Y_W-1:0]    y;
    } t_store_rd;

    // store write-back of one voxel
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
        logic [Y_W-1:0]    y;
        logic              plane_bit;
        logic [1:0]        row_bits;
    } t_store_wr;

    // saturate a size into [2, hi]
    function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                   input logic [SZ_W-1:0] hi);
        logic [SZ_W-1:0] res;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ src/scc_store.sv @@
// scc_store: previous-slice plane memory and previous-row memory,
// one registered read and one write per cycle each; uses scc_pkg
module scc_store import scc_pkg::*; (
    input  logic       i_clk,
    input  t_store_rd  i_rd,
    input  t_store_wr  i_wr,
    output logic       o_plane_bit,
    output logic [1:0] o_row_bits
);

    logic             r_plane_mem [0:MAX_X*MAX_Y-1];
    logic [1:0]       r_row_mem   [0:MAX_Y-1];
    logic             r_plane_q;
    logic [1:0]       r_row_q;

    // plane memory: slice bit per (x,y)
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_plane_mem[i_wr.addr] <= i_wr.plane_bit;
        end
        if (i_rd.en) begin
            r_plane_q <= r_plane_mem[i_rd.addr];
        end
    end

    // row memory: current and previous slice bits per y
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_row_mem[i_wr.y] <= i_wr.row_bits;
        end
        if (i_rd.en) begin
            r_row_q <= r_row_mem[i_rd.y];
        end
    end

    assign o_plane_bit = r_plane_q;
    assign o_row_bits  = r_row_q;

endmodule

@@ src/surface_cube_classifier.sv @@
// surface_cube_classifier: top level, raster counters, cube mask and output register
// depends on scc_pkg and scc_store
//
// Takes one voxel occupancy bit per cycle while o_stall is low, in raster order (z
// outermost, then x, y fastest) and emits one transaction for each cube whose high
// corner has x, y and z all at least 1 and that holds between 1 and 7 occupied
// corners. An accepted voxel reads the plane and row memories at its position into
// stage 1, which forms the mask; leaving stage 1 it writes the memories back and
// loads the output register, so throughput is one voxel per cycle unless the output
// stalls; the read-modify-write of the memories is the loop that sets this. Memory
// contents are not cleared at reset; the raster order writes every entry before
// a cube uses it. A write to any size register restarts the raster at the origin.
module surface_cube_classifier import scc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // voxel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_occupied,
    // cube output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [X_W-1:0]       o_cube_x,
    output logic [Y_W-1:0]       o_cube_y,
    output logic [Z_W-1:0]       o_cube_z,
    output logic [7:0]           o_corner_mask,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [SX_W-1:0] r_size_x;
    logic [SY_W-1:0] r_size_y;
    logic [SZ_W-1:0] r_size_z;
    logic [X_W-1:0]  r_pos_x, n_pos_x;
    logic [Y_W-1:0]  r_pos_y, n_pos_y;
    logic [Z_W-1:0]  r_pos_z, n_pos_z;
    logic [3:0]      r_left;
    logic            r_s1_valid;
    logic            r_s1_occ;
    logic [X_W-1:0]  r_s1_x;
    logic [Y_W-1:0]  r_s1_y;
    logic [Z_W-1:0]  r_s1_z;
    logic            r_out_valid;
    logic [X_W-1:0]  r_out_x;
    logic [Y_W-1:0]  r_out_y;
    logic [Z_W-1:0]  r_out_z;
    logic [7:0]      r_out_mask;

    logic            accept, out_blocked, advance, hit, cfg_hit;
    logic            plane_bit;
    logic [1:0]      row_bits;
    logic [7:0]      mask;
    logic [SY_W-1:0] y_inc;
    logic [SX_W-1:0] x_inc;
    logic [SZ_W-1:0] z_inc;
    logic [SZ_W-1:0] size_x_fit;
    logic [SZ_W-1:0] size_y_fit;
    logic [SZ_W-1:0] size_z_fit;
    t_store_rd       rd;
    t_store_wr       wr;

    // handshakes
    assign out_blocked = r_out_valid && i_stall;
    assign o_stall     = r_s1_valid && out_blocked;
    assign accept      = i_valid && !o_stall;
    assign advance     = r_s1_valid && !out_blocked;
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_SIZE_X ||
                         i_cfg_index == CFG_SIZE_Y || i_cfg_index == CFG_SIZE_Z);

    // saturated sizes of the write data
    assign size_x_fit = clamp_size({2'b00, i_cfg_data[SX_W-1:0]}, SIZE_X_MAX);
    assign size_y_fit = clamp_size({2'b00, i_cfg_data[SY_W-1:0]}, SIZE_Y_MAX);
    assign size_z_fit = clamp_size(i_cfg_data, SIZE_Z_MAX);

    // configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST[SX_W-1:0];
            r_size_y <= SIZE_RST[SY_W-1:0];
            r_size_z <= SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= size_x_fit[SX_W-1:0];
                CFG_SIZE_Y: r_size_y <= size_y_fit[SY_W-1:0];
                CFG_SIZE_Z: r_size_z <= size_z_fit;
                default: ;
            endcase
        end
    end

    // raster position of the next voxel
    always_comb begin
        y_inc   = {1'b0, r_pos_y} + 1'b1;
        x_inc   = {1'b0, r_pos_x} + 1'b1;
        z_inc   = {1'b0, r_pos_z} + 1'b1;
        n_pos_x = r_pos_x;
        n_pos_y = y_inc[Y_W-1:0];
        n_pos_z = r_pos_z;
        if (y_inc >= r_size_y) begin
            n_pos_y = '0;
            n_pos_x = x_inc[X_W-1:0];
            if (x_inc >= r_size_x) begin
                n_pos_x = '0;
                n_pos_z = z_inc[Z_W-1:0];
                if (z_inc >= r_size_z) begin
                    n_pos_z = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else if (accept) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
        end
    end

    // memory read at the accepted voxel's position
    assign rd.en   = accept;
    assign rd.addr = {r_pos_x, r_pos_y};
    assign rd.y    = r_pos_y;

    scc_store u_store (
        .i_clk       (i_clk),
        .i_rd        (rd),
        .i_wr        (wr),
        .o_plane_bit (plane_bit),
        .o_row_bits  (row_bits)
    );

    // stage 1: voxel waiting on its memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_occ <= i_occupied;
            r_s1_x   <= r_pos_x;
            r_s1_y   <= r_pos_y;
            r_s1_z   <= r_pos_z;
        end
    end

    // corner mask and boundary test
    always_comb begin
        mask = {row_bits[0], r_s1_occ, r_left[0], r_left[2],
                row_bits[1], plane_bit, r_left[1], r_left[3]};
        hit  = (r_s1_x != '0) && (r_s1_y != '0) && (r_s1_z != '0) &&
               (mask != 8'h00) && (mask != 8'hFF);
    end

    // write-back as the voxel leaves stage 1
    assign wr.en        = advance;
    assign wr.addr      = {r_s1_x, r_s1_y};
    assign wr.y         = r_s1_y;
    assign wr.plane_bit = r_s1_occ;
    assign wr.row_bits  = {plane_bit, r_s1_occ};

    // left neighbor bits of the previous voxel in the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_left <= '0;
        end else if (advance) begin
            r_left <= {row_bits, plane_bit, r_s1_occ};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= advance && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_blocked && advance && hit) begin
            r_out_x    <= r_s1_x;
            r_out_y    <= r_s1_y;
            r_out_z    <= r_s1_z;
            r_out_mask <= mask;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cube_x      = r_out_x;
    assign o_cube_y      = r_out_y;
    assign o_cube_z      = r_out_z;
    assign o_corner_mask = r_out_mask;

    // emitted cube is a real boundary cell
    a_mask_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mask != 8'h00 && r_out_mask != 8'hFF))
        else $error("emitted cube mask is empty or full");

    a_coords_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_x != '0 && r_out_y != '0 && r_out_z != '0))
        else $error("emitted cube lies on the border");

    // a boundary voxel leaving stage 1 lands in the output register
    a_hit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && hit |=> r_out_valid)
        else $error("boundary cube dropped");

    // stage 1 never overwritten while it holds a voxel
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_blocked |-> !accept && !wr.en)
        else $error("stage 1 overrun while output stalled");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for surface_cube_classifier
// streams directed and random voxel volumes, predicts every boundary cube, checks in order
// depends on scc_pkg and surface_cube_classifier
`timescale 1ns / 100ps

module tb_top;
    import scc_pkg::*;

    // index past the register list, the block ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CFG_DAT_W-1:0] NO_DATA = '0;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned RANDOM_VOXELS = 100;
    localparam int N_DIRECTED = 31;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [Z_W-1:0] z;
        logic [7:0]     mask;
    } t_cube;

    localparam t_cube NO_CUBE = '0;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_VOX_MODEL,
        ROW_VOX_NONE,
        ROW_VOX_CUBE
    } t_row_kind;

    // one directed step: a register write or a voxel with its expected outcome
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DAT_W-1:0]   data;
        logic                   occ;
        t_cube                  cube;
    } t_step_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_occupied = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [X_W-1:0]       o_cube_x;
    logic [Y_W-1:0]       o_cube_y;
    logic [Z_W-1:0]       o_cube_z;
    logic [7:0]           o_corner_mask;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    surface_cube_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_occupied    (i_occupied),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cube_x      (o_cube_x),
        .o_cube_y      (o_cube_y),
        .o_cube_z      (o_cube_z),
        .o_corner_mask (o_corner_mask),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state: previous slice, previous row, left neighbors, position, sizes
    bit                slice_bits [MAX_X*MAX_Y];
    bit [1:0]          row_bits [MAX_Y];
    bit [3:0]          left_bits = '0;
    int unsigned       at_x = 0;
    int unsigned       at_y = 0;
    int unsigned       at_z = 0;
    logic [SX_W-1:0]   size_x_reg = SIZE_RST[SX_W-1:0];
    logic [SY_W-1:0]   size_y_reg = SIZE_RST[SY_W-1:0];
    logic [SZ_W-1:0]   size_z_reg = SIZE_RST;

    t_cube             pending_cubes [$];
    int unsigned       cube_errors = 0;
    int unsigned       voxels_sent = 0;
    int unsigned       idle_cycles = 0;
    bit                send_calm = 1'b0;
    int unsigned       send_calm_left = 0;

    // grid on a 2x2x3 volume: single corner, seven corners, empty and full cubes
    t_step_row directed_rows [N_DIRECTED] = '{
        // right after reset, x = 0 column: border voxels, no cube
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        // 2 x 2 x 3 grid, then a write past the register list
        '{ROW_CFG, CFG_SIZE_X, 11'd2, 1'b0, NO_CUBE},
        '{ROW_CFG, CFG_SIZE_Y, 11'd2, 1'b0, NO_CUBE},
        '{ROW_CFG, CFG_SIZE_Z, 11'd3, 1'b0, NO_CUBE},
        '{ROW_CFG, CFG_SPARE, 11'h7FF, 1'b0, NO_CUBE},
        // only the origin set: one corner at z = 1, empty cube at z = 2
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_CUBE, CFG_SIZE_X, NO_DATA, 1'b0, '{8'd1, 8'd1, 10'd1, 8'h01}},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        // all but the origin set: seven corners at z = 1, full cube at z = 2
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b0, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_CUBE, CFG_SIZE_X, NO_DATA, 1'b1, '{8'd1, 8'd1, 10'd1, 8'hFE}},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE},
        '{ROW_VOX_NONE, CFG_SIZE_X, NO_DATA, 1'b1, NO_CUBE}
    };

    // saturate a programmed size into [2, hi]
    function automatic int unsigned fit_extent(input int unsigned v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // wait draw per transaction, with calm stretches of no idling
    function automatic int unsigned draw_wait(inout bit calm, inout int unsigned left);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // corner mask of the cube ending at the current voxel, then store and raster update
    function automatic bit classify_voxel(input logic occ, output t_cube cube);
        int unsigned ext_x;
        int unsigned ext_y;
        int unsigned ext_z;
        int unsigned slot;
        bit          p;
        bit [1:0]    r;
        bit [7:0]    m;
        bit          hit;
        ext_x = fit_extent(size_x_reg, SIZE_X_MAX);
        ext_y = fit_extent(size_y_reg, SIZE_Y_MAX);
        ext_z = fit_extent(size_z_reg, SIZE_Z_MAX);
        slot = at_x * MAX_Y + at_y;
        p = slice_bits[slot];
        r = row_bits[at_y];
        m = {r[0], occ, left_bits[0], left_bits[2],
             r[1], p, left_bits[1], left_bits[3]};
        hit = (at_x >= 1) && (at_y >= 1) && (at_z >= 1)
              && (m != 8'h00) && (m != 8'hFF);
        cube.x = at_x[X_W-1:0];
        cube.y = at_y[Y_W-1:0];
        cube.z = at_z[Z_W-1:0];
        cube.mask = m;
        slice_bits[slot] = occ;
        row_bits[at_y] = {p, occ};
        left_bits = {r, p, occ};
        // raster advance: y fastest, then x, then z, wrap at end of volume
        at_y++;
        if (at_y >= ext_y) begin
            at_y = 0;
            at_x++;
            if (at_x >= ext_x) begin
                at_x = 0;
                at_z++;
                if (at_z >= ext_z) at_z = 0;
            end
        end
        return hit;
    endfunction

    // drop voxel valid and let the pipeline drain before touching registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_cubes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write transaction, mirrored into the predictor
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DAT_W-1:0] data);
        bit restart;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        restart = 1'b1;
        case (idx)
            CFG_SIZE_X: size_x_reg = data[SX_W-1:0];
            CFG_SIZE_Y: size_y_reg = data[SY_W-1:0];
            CFG_SIZE_Z: size_z_reg = data[SZ_W-1:0];
            default: restart = 1'b0;
        endcase
        if (restart) begin
            at_x = 0;
            at_y = 0;
            at_z = 0;
            left_bits = '0;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one voxel transaction; the expectation is typed in or comes from the predictor
    task automatic send_voxel(input logic occ, input t_row_kind chk, input t_cube typed);
        int unsigned gap;
        t_cube       predicted;
        bit          hit;
        gap = draw_wait(send_calm, send_calm_left);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_occupied <= occ;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        voxels_sent++;
        hit = classify_voxel(occ, predicted);
        case (chk)
            ROW_VOX_CUBE: pending_cubes = {pending_cubes, typed};
            ROW_VOX_MODEL: begin
                if (hit) begin
                    pending_cubes = {pending_cubes, predicted};
                end
            end
            default: ;
        endcase
    endtask

    // program the selected sizes, then stream a volume of density or blob content
    // n_vox of zero picks a length from about half a volume to two volumes, capped for big grids
    task automatic run_phase(input logic [CFG_DAT_W-1:0] dx, input logic [CFG_DAT_W-1:0] dy,
                             input logic [CFG_DAT_W-1:0] dz, input bit [2:0] sel,
                             input int unsigned n_vox);
        int unsigned ext_x;
        int unsigned ext_y;
        int unsigned ext_z;
        int unsigned vol;
        int unsigned fill_pct;
        bit          shaped;
        int          cx;
        int          cy;
        int          cz;
        int          rad;
        int          d2;
        logic        occ;
        if (sel[0]) write_size(CFG_SIZE_X, dx);
        if (sel[1]) write_size(CFG_SIZE_Y, dy);
        if (sel[2]) write_size(CFG_SIZE_Z, dz);
        if ($urandom_range(0, 7) == 0)
            write_size(CFG_SPARE, CFG_DAT_W'($urandom_range(0, 2047)));
        ext_x = fit_extent(size_x_reg, SIZE_X_MAX);
        ext_y = fit_extent(size_y_reg, SIZE_Y_MAX);
        ext_z = fit_extent(size_z_reg, SIZE_Z_MAX);
        vol = ext_x * ext_y * ext_z;
        if (n_vox == 0) begin
            n_vox = $urandom_range(vol / 2 + 1, 2 * vol + 3);
            if (n_vox > 240) n_vox = $urandom_range(120, 240);
        end
        case ($urandom_range(0, 3))
            0: fill_pct = 10;
            1: fill_pct = 50;
            2: fill_pct = 90;
            default: fill_pct = $urandom_range(0, 100);
        endcase
        shaped = $urandom_range(0, 1);
        cx = $urandom_range(0, ext_x - 1);
        cy = $urandom_range(0, ext_y - 1);
        cz = $urandom_range(0, ext_z - 1);
        rad = $urandom_range(1, (ext_x + ext_y + ext_z) / 4 + 1);
        repeat (n_vox) begin
            if (shaped) begin
                d2 = (int'(at_x) - cx) * (int'(at_x) - cx)
                   + (int'(at_y) - cy) * (int'(at_y) - cy)
                   + (int'(at_z) - cz) * (int'(at_z) - cz);
                occ = (d2 < rad * rad) ^ ($urandom_range(0, 99) < 4);
            end else begin
                occ = ($urandom_range(0, 99) < fill_pct);
            end
            send_voxel(occ, ROW_VOX_MODEL, NO_CUBE);
        end
    endtask

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side stall pattern
    initial begin : cube_sink
        int unsigned hold;
        bit          calm;
        int unsigned calm_left;
        calm = 1'b0;
        calm_left = 0;
        forever begin
            hold = draw_wait(calm, calm_left);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid === 1'b1));
        end
    end

    // in-order check of every accepted cube transaction
    always @(posedge i_clk) begin : cube_check
        t_cube got;
        t_cube want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got = {o_cube_x, o_cube_y, o_cube_z, o_corner_mask};
            if (pending_cubes.size() == 0) begin
                cube_errors++;
                if (cube_errors <= 10)
                    $display("unexpected cube: x=%0d y=%0d z=%0d mask=%02h",
                             got.x, got.y, got.z, got.mask);
            end else begin
                want = pending_cubes.pop_front();
                if (got !== want) begin
                    cube_errors++;
                    if (cube_errors <= 10)
                        $display("mismatch: want %0d/%0d/%0d/%02h got %0d/%0d/%0d/%02h",
                                 want.x, want.y, want.z, want.mask,
                                 got.x, got.y, got.z, got.mask);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin : hang_watch
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin : stimulus
        int unsigned                base_vox;
        logic [CFG_DAT_W-1:0]       dx;
        logic [CFG_DAT_W-1:0]       dy;
        logic [CFG_DAT_W-1:0]       dz;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_size(directed_rows[i].idx, directed_rows[i].data);
            else
                send_voxel(directed_rows[i].occ, directed_rows[i].kind, directed_rows[i].cube);
        end

        // extreme grids: x to 255 with saturated sizes, y counter at its top, narrow z column
        run_phase(11'h7FF, 11'd2, 11'h7FF, 3'b111, 1030);
        run_phase(11'd2, 11'd256, 11'd0, 3'b111, 260);
        run_phase(11'd1, 11'd0, 11'd1024, 3'b111, 24);

        // random grids, mostly small
        base_vox = voxels_sent;
        while (voxels_sent - base_vox < RANDOM_VOXELS) begin
            dx = ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom_range(0, 2047))
                                             : CFG_DAT_W'($urandom_range(0, 9));
            dy = ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom_range(0, 2047))
                                             : CFG_DAT_W'($urandom_range(0, 9));
            dz = ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom_range(0, 2047))
                                             : CFG_DAT_W'($urandom_range(0, 6));
            run_phase(dx, dy, dz, 3'($urandom_range(1, 7)), 0);
        end

        wait_idle();
        if (cube_errors == 0 && pending_cubes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
